// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL in this folder.
// No dependencies; expects clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lcb_pkg.sv -----
// Package for the link connect backoff FSM: types, codes and register resets.
// No dependencies.
package lcb_pkg;

  localparam int unsigned TimeW  = 18;
  localparam int unsigned ShiftW = 4;
  localparam int unsigned RetryW = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned WideW  = TimeW + (1 << ShiftW) - 1;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_CONNECT_TIMEOUT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BACKOFF_BASE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BACKOFF_MAX     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SHIFT       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_AUTHORIZE_DELAY = 3'd4;

  // Register reset values
  localparam logic [TimeW-1:0]  RST_CONNECT_TIMEOUT = 18'd15000;
  localparam logic [TimeW-1:0]  RST_BACKOFF_BASE    = 18'd5000;
  localparam logic [TimeW-1:0]  RST_BACKOFF_MAX     = 18'd60000;
  localparam logic [ShiftW-1:0] RST_MAX_SHIFT       = 4'd6;
  localparam logic [TimeW-1:0]  RST_AUTHORIZE_DELAY = 18'd3000;

  // Input opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_PROV  = 2'd2;

  // Radio status
  localparam logic [1:0] LS_PENDING   = 2'd0;
  localparam logic [1:0] LS_CONNECTED = 2'd1;
  localparam logic [1:0] LS_FAILED    = 2'd2;

  // Reported link state
  localparam logic [1:0] LINK_DISC       = 2'd0;
  localparam logic [1:0] LINK_CONNECTING = 2'd1;
  localparam logic [1:0] LINK_CONNECTED  = 2'd2;
  localparam logic [1:0] LINK_RECONN     = 2'd3;

  // Connect stage
  localparam logic [1:0] STG_NONE        = 2'd0;
  localparam logic [1:0] STG_CONNECTING  = 2'd1;
  localparam logic [1:0] STG_AUTHORIZING = 2'd2;
  localparam logic [1:0] STG_CONNECTED   = 2'd3;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ATTEMPT   = 3'd1,
    EV_CONNECTED = 3'd2,
    EV_FAILED    = 3'd3,
    EV_TIMEOUT   = 3'd4,
    EV_LINK_LOST = 3'd5,
    EV_PROV      = 3'd6
  } event_e;

  typedef enum logic [3:0] {
    ST_DISC       = 4'b0001,
    ST_CONNECTING = 4'b0010,
    ST_CONNECTED  = 4'b0100,
    ST_RECONN     = 4'b1000
  } conn_state_e;

endpackage

// ----- rtl/core/link_connect_backoff_fsm_unit.sv -----
// Link connection manager with exponential backoff reconnect.
// Depends on lcb_pkg and assert_macros.svh.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------------
//  in       | sink      | in_valid_i / in_ready_o  | op, link_status, creds, prov done
//  out      | source    | out_valid_o / out_ready_i| state, mode, retries, stage, pulses
//  cfg      | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_ready_i stays high; results are held in the result register.
// Input register -> combinational FSM update and backoff shift/compare -> result register.
// A stalled result stops the input register only once it is full.
// Reset clears the FSM, counters, mode and handshake flags; registers take their defaults.
// Config writes are always taken (cfg_ready_o tied high); unknown indexes are dropped.
`include "assert_macros.svh"

module link_connect_backoff_fsm_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input items
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic [1:0]                   link_status_i,
  input  logic                         creds_present_i,
  input  logic                         provisioning_done_i,
  // Results
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   link_state_o,
  output logic                         provisioning_mode_o,
  output logic [lcb_pkg::RetryW-1:0]   retry_count_o,
  output logic [1:0]                   connect_stage_o,
  output logic                         start_attempt_o,
  output logic                         start_provisioning_o,
  output logic [2:0]                   event_code_o,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lcb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lcb_pkg::TimeW-1:0]    cfg_data_i
);
  import lcb_pkg::*;

  // Configuration registers
  logic [TimeW-1:0]  timeout_q, base_q, max_q, auth_delay_q;
  logic [ShiftW-1:0] max_shift_q;

  // Input register
  logic       in_vld_q;
  logic [1:0] op_q, status_q;
  logic       creds_q, done_q;

  // FSM state
  conn_state_e       conn_q, conn_d;
  logic              prov_q, prov_d;
  logic [RetryW-1:0] retries_q, retries_d;
  logic [TimeW-1:0]  elapsed_q, elapsed_d;
  logic [TimeW-1:0]  wait_q, wait_d;

  // Result register
  logic              out_vld_q;
  logic [1:0]        link_state_q, stage_q;
  logic              prov_out_q, pulse_att_q, pulse_prov_q;
  logic [RetryW-1:0] retries_out_q;
  event_e            event_q;

  // Combinational update results
  logic              pulse_att, pulse_prov;
  event_e            event_d;
  logic [1:0]        link_state_d, stage_d;
  logic              advance;

  // Backoff scheduling
  logic [RetryW-1:0] retry_src, retry_inc, retry_lim, retries_sched;
  logic [ShiftW-1:0] shamt;
  logic [WideW-1:0]  wait_wide;
  logic [TimeW-1:0]  wait_sched;
  logic [TimeW-1:0]  elapsed_tick, wait_tick;

  // Handshakes: the input register moves on whenever the result register is free
  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= RST_CONNECT_TIMEOUT;
      base_q       <= RST_BACKOFF_BASE;
      max_q        <= RST_BACKOFF_MAX;
      max_shift_q  <= RST_MAX_SHIFT;
      auth_delay_q <= RST_AUTHORIZE_DELAY;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CONNECT_TIMEOUT: timeout_q    <= cfg_data_i;
        CFG_BACKOFF_BASE:    base_q       <= cfg_data_i;
        CFG_BACKOFF_MAX:     max_q        <= cfg_data_i;
        CFG_MAX_SHIFT:       max_shift_q  <= cfg_data_i[ShiftW-1:0];
        CFG_AUTHORIZE_DELAY: auth_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= op_i;
      status_q <= link_status_i;
      creds_q  <= creds_present_i;
      done_q   <= provisioning_done_i;
    end
  end

  // Retry wait: base << min(retries, max_shift), capped. A lost link counts from zero.
  always_comb begin
    retry_src = (conn_q == ST_CONNECTED) ? '0 : retries_q;
    shamt     = (retry_src < {1'b0, max_shift_q}) ? retry_src[ShiftW-1:0] : max_shift_q;
    wait_wide = {{(WideW-TimeW){1'b0}}, base_q} << shamt;
    wait_sched = (wait_wide > {{(WideW-TimeW){1'b0}}, max_q}) ? max_q : wait_wide[TimeW-1:0];
    retry_lim  = {1'b0, max_shift_q} + RetryW'(1);
    retry_inc  = retry_src + RetryW'(1);
    retries_sched = (retry_inc < retry_lim) ? retry_inc : retry_lim;
  end

  // Time advance on a tick
  assign elapsed_tick = (conn_q == ST_CONNECTING && elapsed_q != '1) ?
                        elapsed_q + TimeW'(1) : elapsed_q;
  assign wait_tick    = (wait_q != '0) ? wait_q - TimeW'(1) : wait_q;

  // Main FSM update
  always_comb begin
    conn_d     = conn_q;
    prov_d     = prov_q;
    retries_d  = retries_q;
    elapsed_d  = elapsed_q;
    wait_d     = wait_q;
    pulse_att  = 1'b0;
    pulse_prov = 1'b0;
    event_d    = EV_NONE;
    unique case (op_q)
      OP_TICK: begin
        elapsed_d = elapsed_tick;
        wait_d    = wait_tick;
        if (prov_q) begin
          if (done_q) begin
            prov_d    = 1'b0;
            retries_d = '0;
            conn_d    = ST_CONNECTING;
            elapsed_d = '0;
            pulse_att = 1'b1;
            event_d   = EV_ATTEMPT;
          end
        end else begin
          unique case (conn_q)
            ST_DISC, ST_RECONN: begin
              if (creds_q && wait_tick == '0) begin
                conn_d    = ST_CONNECTING;
                elapsed_d = '0;
                pulse_att = 1'b1;
                event_d   = EV_ATTEMPT;
              end
            end
            ST_CONNECTING: begin
              priority if (status_q == LS_CONNECTED) begin
                conn_d    = ST_CONNECTED;
                retries_d = '0;
                event_d   = EV_CONNECTED;
              end else if (status_q == LS_FAILED) begin
                conn_d    = ST_DISC;
                retries_d = retries_sched;
                wait_d    = wait_sched;
                event_d   = EV_FAILED;
              end else if (elapsed_tick >= timeout_q) begin
                conn_d    = ST_DISC;
                retries_d = retries_sched;
                wait_d    = wait_sched;
                event_d   = EV_TIMEOUT;
              end else begin
                // attempt still pending
              end
            end
            ST_CONNECTED: begin
              if (status_q != LS_CONNECTED) begin
                conn_d    = ST_RECONN;
                retries_d = retries_sched;
                wait_d    = wait_sched;
                event_d   = EV_LINK_LOST;
              end
            end
            default: ;
          endcase
        end
      end
      OP_START: begin
        if (!creds_q) begin
          if (!prov_q) begin
            prov_d     = 1'b1;
            conn_d     = ST_DISC;
            pulse_prov = 1'b1;
            event_d    = EV_PROV;
          end
        end else begin
          prov_d    = 1'b0;
          retries_d = '0;
          conn_d    = ST_CONNECTING;
          elapsed_d = '0;
          pulse_att = 1'b1;
          event_d   = EV_ATTEMPT;
        end
      end
      OP_PROV: begin
        if (!prov_q) begin
          prov_d     = 1'b1;
          conn_d     = ST_DISC;
          pulse_prov = 1'b1;
          event_d    = EV_PROV;
        end
      end
      default: ;  // unused opcode: no effect
    endcase
  end

  // Reported state and stage after the update
  always_comb begin
    link_state_d = LINK_DISC;
    stage_d      = STG_NONE;
    unique case (conn_d)
      ST_DISC:   link_state_d = LINK_DISC;
      ST_RECONN: link_state_d = LINK_RECONN;
      ST_CONNECTING: begin
        link_state_d = LINK_CONNECTING;
        stage_d      = (elapsed_d < auth_delay_q) ? STG_CONNECTING : STG_AUTHORIZING;
      end
      ST_CONNECTED: begin
        link_state_d = LINK_CONNECTED;
        stage_d      = STG_CONNECTED;
      end
      default: ;
    endcase
  end

  // State registers follow each transfer out of the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q    <= ST_DISC;
      prov_q    <= 1'b0;
      retries_q <= '0;
      elapsed_q <= '0;
      wait_q    <= '0;
    end else if (advance) begin
      conn_q    <= conn_d;
      prov_q    <= prov_d;
      retries_q <= retries_d;
      elapsed_q <= elapsed_d;
      wait_q    <= wait_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      link_state_q  <= link_state_d;
      stage_q       <= stage_d;
      prov_out_q    <= prov_d;
      retries_out_q <= retries_d;
      pulse_att_q   <= pulse_att;
      pulse_prov_q  <= pulse_prov;
      event_q       <= event_d;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign link_state_o         = link_state_q;
  assign provisioning_mode_o  = prov_out_q;
  assign retry_count_o        = retries_out_q;
  assign connect_stage_o      = stage_q;
  assign start_attempt_o      = pulse_att_q;
  assign start_provisioning_o = pulse_prov_q;
  assign event_code_o         = event_q;

  // Result shape that must go with an attempt pulse
  logic attempt_ok;
  assign attempt_ok = (link_state_q == LINK_CONNECTING) && (event_q == EV_ATTEMPT);

  `ASSERT_NEXT(a_adv_fills_out, advance, out_vld_q, "result register not loaded on transfer")
  `ASSERT_IMPLY(a_pulses_excl, out_vld_q, !(pulse_att_q && pulse_prov_q), "both pulses set")
  `ASSERT_IMPLY(a_attempt_stage, out_vld_q && pulse_att_q, attempt_ok, "attempt pulse mismatch")
  `ASSERT_ALWAYS(a_retry_bound, retries_q <= RetryW'(16), "retry count above saturation")

endmodule

// ----- sim/link_connect_backoff_fsm_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for link_connect_backoff_fsm_unit: own predictor, queued
// stimulus, random idling on both channels. Depends on lcb_pkg and the unit's RTL.
module link_connect_backoff_fsm_unit_tb;
  import lcb_pkg::*;

  // Codes the package leaves unnamed but the ports can carry
  localparam logic [1:0]         OP_UNUSED    = 2'd3;
  localparam logic [1:0]         LS_UNUSED    = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [TimeW-1:0]   TIME_MAX     = {TimeW{1'b1}};
  localparam int unsigned        WATCHDOG_LIMIT = 4000;
  localparam int unsigned        SETTLE_CYCLES  = 10;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] status;
    logic       creds;
    logic       done;
  } link_item_t;

  typedef struct packed {
    logic [1:0]        link_state;
    logic              prov_mode;
    logic [RetryW-1:0] retries;
    logic [1:0]        stage;
    logic              attempt_pulse;
    logic              prov_pulse;
    event_e            ev;
  } link_result_t;

  // Clock, reset and every input start at a known value
  logic               clk_i               = 1'b0;
  logic               rst_ni              = 1'b0;
  logic               in_valid_i          = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i                = OP_TICK;
  logic [1:0]         link_status_i       = LS_PENDING;
  logic               creds_present_i     = 1'b0;
  logic               provisioning_done_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i         = 1'b0;
  logic [1:0]         link_state_o;
  logic               provisioning_mode_o;
  logic [RetryW-1:0]  retry_count_o;
  logic [1:0]         connect_stage_o;
  logic               start_attempt_o;
  logic               start_provisioning_o;
  logic [2:0]         event_code_o;
  logic               cfg_valid_i         = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i         = CFG_CONNECT_TIMEOUT;
  logic [TimeW-1:0]   cfg_data_i          = '0;

  link_connect_backoff_fsm_unit DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .op_i                 (op_i),
    .link_status_i        (link_status_i),
    .creds_present_i      (creds_present_i),
    .provisioning_done_i  (provisioning_done_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .link_state_o         (link_state_o),
    .provisioning_mode_o  (provisioning_mode_o),
    .retry_count_o        (retry_count_o),
    .connect_stage_o      (connect_stage_o),
    .start_attempt_o      (start_attempt_o),
    .start_provisioning_o (start_provisioning_o),
    .event_code_o         (event_code_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted copy of the link manager. Registers mirror the unit's defaults and
  // follow every configuration transfer seen on the bus.
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0]  p_timeout    = RST_CONNECT_TIMEOUT;
  logic [TimeW-1:0]  p_base       = RST_BACKOFF_BASE;
  logic [TimeW-1:0]  p_cap        = RST_BACKOFF_MAX;
  logic [ShiftW-1:0] p_max_shift  = RST_MAX_SHIFT;
  logic [TimeW-1:0]  p_auth_delay = RST_AUTHORIZE_DELAY;
  logic              p_prov       = 1'b0;
  logic [1:0]        p_state      = LINK_DISC;
  logic [RetryW-1:0] p_retries    = '0;
  logic [TimeW-1:0]  p_elapsed    = '0;
  logic [TimeW-1:0]  p_wait_left  = '0;

  link_item_t   pending_items[$];     // waiting for the driver
  link_result_t expected_results[$];  // predicted, not yet seen on the output
  int unsigned  outstanding   = 0;    // items queued whose result is still due
  int unsigned  fail_count    = 0;
  int unsigned  phase_count   = 0;    // items that do something, this phase
  int unsigned  in_idle_pct   = 10;
  int unsigned  out_idle_pct  = 15;
  int unsigned  quiet_max     = 20;
  logic         item_taken    = 1'b0;
  logic         reg_taken     = 1'b0;
  int unsigned  stuck_cycles  = 0;

  function automatic void open_attempt(inout link_result_t r);
    p_state = LINK_CONNECTING;
    p_elapsed = '0;
    r.attempt_pulse = 1'b1;
    r.ev = EV_ATTEMPT;
  endfunction

  function automatic void enter_setup_mode(inout link_result_t r);
    if (!p_prov) begin
      p_prov = 1'b1;
      p_state = LINK_DISC;
      r.prov_pulse = 1'b1;
      r.ev = EV_PROV;
    end
  endfunction

  // Backoff is base << min(retries, max_shift), capped; the count saturates at max_shift+1
  function automatic void schedule_reconnect(logic [1:0] next_state);
    logic [RetryW-1:0] sh;
    logic [RetryW-1:0] lim;
    logic [63:0]       hold_ticks;
    sh = (p_retries < p_max_shift) ? p_retries : RetryW'(p_max_shift);
    lim = RetryW'(p_max_shift) + 1'b1;
    hold_ticks = 64'(p_base);
    hold_ticks = hold_ticks << sh;
    if (hold_ticks > 64'(p_cap)) hold_ticks = 64'(p_cap);
    p_retries = (p_retries + 1'b1 < lim) ? p_retries + 1'b1 : lim;
    p_wait_left = hold_ticks[TimeW-1:0];
    p_state = next_state;
  endfunction

  function automatic link_result_t predict_link(link_item_t it);
    link_result_t r;
    r = '0;
    r.ev = EV_NONE;
    case (it.op)
      OP_TICK: begin
        // time moves first, then the state machine looks at the status
        if (p_state == LINK_CONNECTING && p_elapsed != TIME_MAX) p_elapsed++;
        if (p_wait_left != '0) p_wait_left--;
        if (p_prov) begin
          if (it.done) begin
            p_prov = 1'b0;
            p_retries = '0;
            open_attempt(r);
          end
        end else begin
          case (p_state)
            LINK_DISC, LINK_RECONN: begin
              if (it.creds && p_wait_left == '0) open_attempt(r);
            end
            LINK_CONNECTING: begin
              if (it.status == LS_CONNECTED) begin
                p_state = LINK_CONNECTED;
                p_retries = '0;
                r.ev = EV_CONNECTED;
              end else if (it.status == LS_FAILED) begin
                schedule_reconnect(LINK_DISC);
                r.ev = EV_FAILED;
              end else if (p_elapsed >= p_timeout) begin
                schedule_reconnect(LINK_DISC);
                r.ev = EV_TIMEOUT;
              end
            end
            default: begin
              // link lost: retries start over before the backoff is worked out
              if (it.status != LS_CONNECTED) begin
                p_retries = '0;
                schedule_reconnect(LINK_RECONN);
                r.ev = EV_LINK_LOST;
              end
            end
          endcase
        end
      end
      OP_START: begin
        if (!it.creds) begin
          enter_setup_mode(r);
        end else begin
          p_prov = 1'b0;
          p_retries = '0;
          open_attempt(r);
        end
      end
      OP_PROV: enter_setup_mode(r);
      default: ;  // unused op leaves everything alone
    endcase

    if (p_state == LINK_CONNECTED) begin
      r.stage = STG_CONNECTED;
    end else if (p_state == LINK_CONNECTING) begin
      r.stage = (p_elapsed < p_auth_delay) ? STG_CONNECTING : STG_AUTHORIZING;
    end else begin
      r.stage = STG_NONE;
    end
    r.link_state = p_state;
    r.prov_mode = p_prov;
    r.retries = p_retries;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic int unsigned pick_gap(int unsigned pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < pct) return $urandom_range(1, 3);
    if (pct > 0 && r < pct + 2) return $urandom_range(10, 40);
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: presents queued items on the falling edge and holds each one
  // until its transfer, then leaves a random gap.
  // ---------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(negedge clk_i) begin : drive_items
    link_item_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || item_taken) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap--;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          op_i                <= nxt.op;
          link_status_i       <= nxt.status;
          creds_present_i     <= nxt.creds;
          provisioning_done_i <= nxt.done;
          in_valid_i          <= 1'b1;
          send_gap = pick_gap(in_idle_pct);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure, independent of whether anything is waiting
  int unsigned recv_stall = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_stall > 0) begin
        out_ready_i <= 1'b0;
        recv_stall--;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall = pick_gap(out_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled on the rising edge. Results are checked
  // before the item transferred in the same cycle is predicted, since a result
  // can never belong to an item taken on that very edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    link_result_t want;
    link_item_t   got_item;
    if (!rst_ni) begin
      item_taken   <= 1'b0;
      reg_taken    <= 1'b0;
      stuck_cycles <= 0;
    end else begin
      item_taken <= in_valid_i && in_ready_o;
      reg_taken  <= cfg_valid_i && cfg_ready_o;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CONNECT_TIMEOUT: p_timeout    = cfg_data_i;
          CFG_BACKOFF_BASE:    p_base       = cfg_data_i;
          CFG_BACKOFF_MAX:     p_cap        = cfg_data_i;
          CFG_MAX_SHIFT:       p_max_shift  = cfg_data_i[ShiftW-1:0];
          CFG_AUTHORIZE_DELAY: p_auth_delay = cfg_data_i;
          default: ;  // spare indexes are dropped
        endcase
      end

      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no result expected");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("link_state", 32'(want.link_state), 32'(link_state_o));
          check_field("provisioning_mode", 32'(want.prov_mode), 32'(provisioning_mode_o));
          check_field("retry_count", 32'(want.retries), 32'(retry_count_o));
          check_field("connect_stage", 32'(want.stage), 32'(connect_stage_o));
          check_field("start_attempt", 32'(want.attempt_pulse), 32'(start_attempt_o));
          check_field("start_provisioning", 32'(want.prov_pulse),
                      32'(start_provisioning_o));
          check_field("event_code", 32'(want.ev), 32'(event_code_o));
          outstanding--;
        end
      end

      if (in_valid_i && in_ready_o) begin
        got_item = '{op_i, link_status_i, creds_present_i, provisioning_done_i};
        expected_results.push_back(predict_link(got_item));
      end

      // watchdog: any transfer on any channel counts as progress
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void push_item(logic [1:0] op, logic [1:0] status, logic creds,
                                    logic done);
    pending_items.push_back('{op, status, creds, done});
    outstanding++;
    if (op != OP_UNUSED) phase_count++;
  endfunction

  function automatic logic [1:0] any_status();
    return 2'($urandom_range(0, 3));
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // One segment of traffic. Most segments are plausible radio behaviour (waits,
  // sessions that connect and drop, failures, provisioning rounds) so that the
  // backoff and retry logic is reached; the rest is unrestricted noise.
  function automatic void add_segment();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // quiet stretch: lets attempts time out and backoff waits run down
      n = $urandom_range(1, quiet_max);
      repeat (n) push_item(OP_TICK, ($urandom_range(0, 9) == 0) ? LS_UNUSED : LS_PENDING,
                           1'b1, 1'b0);
    end else if (kind < 57) begin
      // session: optional start, connect, hold, then lose the link
      if ($urandom_range(0, 9) < 7) push_item(OP_START, any_status(), 1'b1, any_bit());
      n = $urandom_range(0, 4);
      repeat (n) push_item(OP_TICK, LS_PENDING, 1'b1, 1'b0);
      push_item(OP_TICK, LS_CONNECTED, 1'b1, 1'b0);
      n = $urandom_range(1, 6);
      repeat (n) push_item(OP_TICK, LS_CONNECTED, any_bit(), any_bit());
      case ($urandom_range(0, 2))
        0: push_item(OP_TICK, LS_PENDING, 1'b1, 1'b0);
        1: push_item(OP_TICK, LS_FAILED, 1'b1, 1'b0);
        default: push_item(OP_TICK, LS_UNUSED, 1'b1, 1'b0);
      endcase
    end else if (kind < 72) begin
      // repeated failures climb the retry count
      n = $urandom_range(1, 8);
      repeat (n) push_item(OP_TICK, LS_FAILED, 1'b1, 1'b0);
    end else if (kind < 80) begin
      // provisioning round, entered either way, ended by the helper
      if ($urandom_range(0, 1)) push_item(OP_PROV, any_status(), any_bit(), 1'b0);
      else push_item(OP_START, any_status(), 1'b0, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) push_item(OP_TICK, any_status(), any_bit(), 1'b0);
      push_item(OP_TICK, any_status(), any_bit(), 1'b1);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) push_item(2'($urandom_range(0, 3)), any_status(), any_bit(), any_bit());
    end
  endfunction

  function automatic void add_random(int unsigned target);
    phase_count = 0;
    while (phase_count < target) add_segment();
  endfunction

  // Configuration transfer; only issued while nothing is outstanding
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!reg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic [TimeW-1:0] tmo, logic [TimeW-1:0] base,
                          logic [TimeW-1:0] cap, logic [ShiftW-1:0] shift,
                          logic [TimeW-1:0] delay);
    write_reg(CFG_CONNECT_TIMEOUT, tmo);
    write_reg(CFG_BACKOFF_BASE, base);
    write_reg(CFG_BACKOFF_MAX, cap);
    write_reg(CFG_MAX_SHIFT, {{(TimeW-ShiftW){1'b0}}, shift});
    write_reg(CFG_AUTHORIZE_DELAY, delay);
  endtask

  // Sender holds off until every predicted result has been seen
  task automatic drain();
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: every op, the unused codes and the provisioning corners
    push_item(OP_UNUSED, LS_UNUSED, 1'b1, 1'b1);
    push_item(OP_TICK, LS_PENDING, 1'b0, 1'b0);
    push_item(OP_PROV, LS_PENDING, 1'b1, 1'b0);
    push_item(OP_PROV, LS_CONNECTED, 1'b1, 1'b0);   // already provisioning
    push_item(OP_START, LS_PENDING, 1'b0, 1'b0);    // no creds, already provisioning
    push_item(OP_TICK, LS_PENDING, 1'b1, 1'b0);
    push_item(OP_TICK, LS_PENDING, 1'b1, 1'b1);     // helper done, attempt begins
    push_item(OP_TICK, LS_UNUSED, 1'b1, 1'b0);      // odd status reads as pending
    push_item(OP_TICK, LS_CONNECTED, 1'b1, 1'b0);
    push_item(OP_TICK, LS_CONNECTED, 1'b0, 1'b1);
    push_item(OP_TICK, LS_UNUSED, 1'b1, 1'b0);      // odd status drops the link
    push_item(OP_START, LS_FAILED, 1'b1, 1'b1);
    push_item(OP_TICK, LS_FAILED, 1'b1, 1'b0);
    push_item(OP_START, LS_PENDING, 1'b0, 1'b0);    // start without creds
    add_random(150);
    drain();

    set_regs(18'd8, 18'd2, 18'd30, 4'd3, 18'd3);
    quiet_max = 14;
    add_random(300);
    drain();

    // Zero timeout, base and delay
    set_regs('0, '0, 18'd5, 4'd4, '0);
    push_item(OP_START, LS_PENDING, 1'b1, 1'b0);    // authorizing straight away
    push_item(OP_TICK, LS_PENDING, 1'b1, 1'b0);     // times out on first tick
    push_item(OP_TICK, LS_PENDING, 1'b1, 1'b0);     // retry with no wait
    push_item(OP_TICK, LS_FAILED, 1'b1, 1'b0);
    push_item(OP_TICK, LS_PENDING, 1'b1, 1'b0);
    add_random(200);
    drain();

    // Smallest legal settings, plus writes to the spare indexes
    set_regs(18'd1, 18'd1, 18'd1, 4'd0, 18'd1);
    write_reg(CFG_SPARE_LO, 18'h2AAAA);
    write_reg(CFG_SPARE_HI, TIME_MAX);
    in_idle_pct = 20;
    add_random(200);
    drain();

    // Widest shift with a tiny cap: retries reach sixteen
    set_regs(18'd2, 18'd1, 18'd3, 4'd15, 18'd2);
    in_idle_pct = 10;
    add_random(250);
    push_item(OP_START, LS_PENDING, 1'b1, 1'b0);
    repeat (100) push_item(OP_TICK, LS_FAILED, 1'b1, 1'b0);
    drain();

    // Shift lowered below the current count: the next retry pulls it down
    write_reg(CFG_MAX_SHIFT, 18'd2);
    repeat (6) push_item(OP_TICK, LS_FAILED, 1'b1, 1'b0);
    add_random(200);
    drain();

    // Largest settings; the shifted base overflows the cap. No idling here.
    set_regs(TIME_MAX, TIME_MAX, TIME_MAX, 4'd15, TIME_MAX);
    in_idle_pct = 0;
    out_idle_pct = 0;
    add_random(150);
    drain();

    // Middle settings under heavy idling
    set_regs(18'd20, 18'd3, 18'd50, 4'd5, 18'd10);
    in_idle_pct = 30;
    out_idle_pct = 30;
    quiet_max = 28;
    add_random(200);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- link_connect_backoff_fsm_unit.f -----
+incdir+rtl/core
rtl/core/lcb_pkg.sv
rtl/core/link_connect_backoff_fsm_unit.sv
sim/link_connect_backoff_fsm_unit_tb.sv
